/* rtl/ghash_pkg.sv */
// shared types and codes for the ghash accumulator
package ghash_pkg;

  localparam int BlockW = 128;
  localparam int HalfW  = 64;

  typedef logic [BlockW-1:0] blk_t;

  localparam logic [1:0] MODE_AAD    = 2'd0;
  localparam logic [1:0] MODE_TEXT   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  // bit-reflected reduction: x^128 = 1 + x + x^2 + x^7 (the 0xe1 constant)
  localparam int RedTap1 = 1;
  localparam int RedTap2 = 2;
  localparam int RedTap7 = 7;

endpackage

/* rtl/ghash_gf128_accumulator_top.sv */
// ghash accumulator top: input stage, accumulator, length counters and hash register
//
// Takes one 128-bit word per clock while data_stall is low: associated data,
// ciphertext or a finish word. A data word is masked to its leading
// valid_bytes bytes, folded into the accumulator and multiplied by H in the
// combinational gf(2^128) multiplier, so a data word never causes a stall. A
// finish word folds in the two bit lengths, loads the hash register and
// clears the accumulator and counters; it goes from the input stage register
// to the hash register, waiting while an earlier hash is still stalled.
// data_stall rises only when a finish word is waiting behind an unread hash
// that is itself stalled. The key registers are written through wr_en /
// wr_index / wr_data and should be changed only when the block is idle.
module ghash_gf128_accumulator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic [4:0]  valid_bytes,
  output logic        hash_valid,
  input  logic        hash_stall,
  output logic [63:0] hash_high,
  output logic [63:0] hash_low
);
  import ghash_pkg::*;

  logic [HalfW-1:0] key_high;
  logic [HalfW-1:0] key_low;
  logic [HalfW-1:0] aad_bits;
  logic [HalfW-1:0] text_bits;
  blk_t             acc;

  logic             st_valid;
  logic [1:0]       st_mode;
  blk_t             st_block;
  logic [7:0]       st_bits;

  logic [4:0]       nv;
  logic [7:0]       in_bits;
  logic [7:0]       keep_shift;
  blk_t             keep_mask;
  logic             accept;
  logic             st_finish;
  logic             st_go;
  blk_t             mul_x;
  blk_t             prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_HIGH: key_high <= wr_data;
        REG_KEY_LOW:  key_low  <= wr_data;
        default: ;
      endcase
    end
  end

  // clamp to a full word and keep the leading bytes only
  assign nv         = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
  assign in_bits    = {nv, 3'b000};
  assign keep_shift = 8'(BlockW) - in_bits;
  assign keep_mask  = ~blk_t'(0) << keep_shift;

  assign st_finish  = (st_mode == MODE_FINISH);
  assign st_go      = st_valid && !(st_finish && hash_valid && hash_stall);
  assign data_stall = st_valid && !st_go;
  assign accept     = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (st_go) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_mode  <= mode;
      st_block <= {block_high, block_low} & keep_mask;
      st_bits  <= in_bits;
    end
  end

  assign mul_x = acc ^ (st_finish ? {aad_bits, text_bits} : st_block);

  ghash_gfmul u_gfmul (
    .x (mul_x),
    .h ({key_high, key_low}),
    .z (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      aad_bits  <= '0;
      text_bits <= '0;
    end else if (st_go) begin
      unique case (st_mode)
        MODE_AAD: begin
          acc      <= prod;
          aad_bits <= aad_bits + HalfW'(st_bits);
        end
        MODE_TEXT: begin
          acc       <= prod;
          text_bits <= text_bits + HalfW'(st_bits);
        end
        MODE_FINISH: begin
          acc       <= '0;
          aad_bits  <= '0;
          text_bits <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (st_go && st_finish) begin
      hash_valid <= 1'b1;
    end else if (!hash_stall) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_go && st_finish) begin
      hash_high <= prod[BlockW-1:HalfW];
      hash_low  <= prod[HalfW-1:0];
    end
  end

endmodule

/* rtl/ghash_gfmul.sv */
// gf(2^128) multiplier in the gcm bit order: carry-less product and two folds
module ghash_gfmul (
  input  ghash_pkg::blk_t x,
  input  ghash_pkg::blk_t h,
  output ghash_pkg::blk_t z
);
  import ghash_pkg::*;

  localparam int ProdW = 2 * BlockW - 1;
  localparam int FoldW = BlockW + RedTap7 - 1;

  logic [BlockW-1:0] a;
  logic [BlockW-1:0] b;
  logic [ProdW-1:0]  p;
  logic [FoldW-1:0]  t;
  logic [BlockW-1:0] r;

  // coefficient k of the polynomial sits at word bit 127-k
  always_comb begin
    for (int k = 0; k < BlockW; k++) begin
      a[k] = x[BlockW-1-k];
      b[k] = h[BlockW-1-k];
    end
  end

  always_comb begin
    for (int k = 0; k < ProdW; k++) begin
      p[k] = 1'b0;
      for (int i = 0; i < BlockW; i++) begin
        if ((k - i >= 0) && (k - i < BlockW)) begin
          p[k] = p[k] ^ (a[i] & b[k-i]);
        end
      end
    end
  end

  // first fold leaves six bits above 127 (up to bit 133), the second clears them
  always_comb begin
    t = '0;
    t[BlockW-1:0] = p[BlockW-1:0];
    for (int k = BlockW; k < ProdW; k++) begin
      t[k-BlockW]         = t[k-BlockW] ^ p[k];
      t[k-BlockW+RedTap1] = t[k-BlockW+RedTap1] ^ p[k];
      t[k-BlockW+RedTap2] = t[k-BlockW+RedTap2] ^ p[k];
      t[k-BlockW+RedTap7] = t[k-BlockW+RedTap7] ^ p[k];
    end
  end

  always_comb begin
    r = t[BlockW-1:0];
    for (int k = BlockW; k < FoldW; k++) begin
      r[k-BlockW]         = r[k-BlockW] ^ t[k];
      r[k-BlockW+RedTap1] = r[k-BlockW+RedTap1] ^ t[k];
      r[k-BlockW+RedTap2] = r[k-BlockW+RedTap2] ^ t[k];
      r[k-BlockW+RedTap7] = r[k-BlockW+RedTap7] ^ t[k];
    end
  end

  always_comb begin
    for (int k = 0; k < BlockW; k++) begin
      z[BlockW-1-k] = r[k];
    end
  end

endmodule
